// ----- src/rsa_pkg.sv -----
// Shared types and codes for the reference-counted slot allocator.
package rsa_pkg;

	// Request commands.
	localparam logic CMD_USE   = 1'b0;
	localparam logic CMD_UNUSE = 1'b1;

	// Result status codes.
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_INVALID  = 3'd1;
	localparam logic [2:0] STAT_DENIED   = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND = 3'd4;
	localparam logic [2:0] STAT_OVERFLOW = 3'd5;

	typedef struct packed {
		logic        command;
		logic [15:0] owner_id;
		logic [7:0]  slot_value;
	} req_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       var_write;
		logic [3:0] var_value;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request and read its slot entry
		logic commit;  // update the table and load the result register
	} rsa_ctl_t;

endpackage

// ----- src/rsa_ctrl.sv -----
// Controller state machine: request acceptance, commit timing and result valid.
module rsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsa_pkg::rsa_ctl_t ctl
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic can_commit;

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = out_valid_q;
	// The result register is free when empty or being emptied this cycle.
	assign can_commit = !out_valid_q || !rsp_stall;

	always_comb begin
		ctl.load   = (state_q == S_IDLE) && req_valid;
		ctl.commit = (state_q == S_EXEC) && can_commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (can_commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.commit)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/rsa_datapath.sv -----
// Datapath: slot table memory, occupancy bits, free-slot search and result register.
module rsa_datapath #(
	parameter int NUM_SLOTS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rsa_pkg::rsa_ctl_t  ctl,
	input  rsa_pkg::req_item_t req,
	output rsa_pkg::rsp_item_t rsp
);

	localparam int SLOT_BITS = $clog2(NUM_SLOTS);

	// Table memory; an entry whose occupancy bit is clear reads as free.
	logic [15:0]           owner_mem [NUM_SLOTS];
	logic [COUNT_BITS-1:0] count_mem [NUM_SLOTS];
	logic                  flag_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  occ_q;

	// Captured request and read data.
	logic                  cmd_q;
	logic [15:0]           owner_q;
	logic [7:0]            sv_q;
	logic [SLOT_BITS-1:0]  free_idx_q;
	logic                  free_found_q;
	logic [15:0]           rd_owner_q;
	logic [COUNT_BITS-1:0] rd_count_q;
	logic                  rd_flag_q;
	logic                  rd_occ_q;
	rsa_pkg::rsp_item_t    rsp_q;

	// Request-side decode.
	logic                  req_in_range;
	logic [SLOT_BITS-1:0]  req_idx;
	logic [SLOT_BITS-1:0]  free_idx;
	logic                  free_found;

	// Execute-side decode.
	logic                  sv_in_range;
	logic [SLOT_BITS-1:0]  sv_idx;
	logic [15:0]           cur_owner;
	logic [COUNT_BITS-1:0] cur_count;
	logic                  cur_flag;
	logic [SLOT_BITS+3:0]  free_idx_ext;

	// Update decisions.
	logic                  wr_en;
	logic [SLOT_BITS-1:0]  wr_idx;
	logic [15:0]           wr_owner;
	logic [COUNT_BITS-1:0] wr_count;
	logic                  wr_flag;
	logic                  occ_set;
	logic                  occ_clr;
	rsa_pkg::rsp_item_t    result;

	assign req_in_range = ({1'b0, req.slot_value} < 9'(NUM_SLOTS));
	assign req_idx      = req_in_range ? req.slot_value[SLOT_BITS-1:0] : '0;

	// Lowest free slot above the reserved slot 0.
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
			if (!occ_q[i]) begin
				free_idx   = SLOT_BITS'(i);
				free_found = 1'b1;
			end
		end
	end

	assign sv_in_range  = ({1'b0, sv_q} < 9'(NUM_SLOTS));
	assign sv_idx       = sv_q[SLOT_BITS-1:0];
	assign cur_owner    = rd_occ_q ? rd_owner_q : '0;
	assign cur_count    = rd_occ_q ? rd_count_q : '0;
	assign cur_flag     = rd_occ_q ? rd_flag_q  : 1'b0;
	assign free_idx_ext = {4'b0000, free_idx_q};

	always_comb begin
		wr_en            = 1'b0;
		wr_idx           = sv_idx;
		wr_owner         = owner_q;
		wr_count         = cur_count;
		wr_flag          = cur_flag;
		occ_set          = 1'b0;
		occ_clr          = 1'b0;
		result.status    = rsa_pkg::STAT_OK;
		result.var_write = 1'b0;
		result.var_value = 4'd0;
		if (cmd_q == rsa_pkg::CMD_USE) begin
			if (owner_q == 16'd0 || !sv_in_range) begin
				result.status = rsa_pkg::STAT_INVALID;
			end else if (sv_q != 8'd0) begin
				if (cur_owner == owner_q) begin
					if (cur_count == '1) begin
						result.status = rsa_pkg::STAT_OVERFLOW;
					end else begin
						wr_en    = 1'b1;
						wr_count = cur_count + 1'b1;
					end
				end else if (cur_owner != 16'd0) begin
					result.status = rsa_pkg::STAT_DENIED;
				end else begin
					// Claiming a named free slot leaves the assigned flag clear.
					wr_en    = 1'b1;
					wr_count = COUNT_BITS'(1);
					wr_flag  = 1'b0;
					occ_set  = 1'b1;
				end
			end else if (free_found_q) begin
				wr_en            = 1'b1;
				wr_idx           = free_idx_q;
				wr_count         = COUNT_BITS'(1);
				wr_flag          = 1'b1;
				occ_set          = 1'b1;
				result.var_write = 1'b1;
				result.var_value = free_idx_ext[3:0];
			end else begin
				result.status = rsa_pkg::STAT_FULL;
			end
		end else begin
			if (owner_q == 16'd0 || sv_q == 8'd0 || !sv_in_range
					|| cur_owner != owner_q) begin
				result.status = rsa_pkg::STAT_NOTFOUND;
			end else if (cur_count > COUNT_BITS'(1)) begin
				wr_en    = 1'b1;
				wr_count = cur_count - 1'b1;
			end else begin
				// Last use gone: free the slot and clear an allocator-set variable.
				occ_clr          = 1'b1;
				result.var_write = cur_flag;
			end
		end
	end

	// Memory: read at request capture, written at commit.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rd_owner_q <= owner_mem[req_idx];
			rd_count_q <= count_mem[req_idx];
			rd_flag_q  <= flag_mem[req_idx];
		end
		if (ctl.commit && wr_en) begin
			owner_mem[wr_idx] <= wr_owner;
			count_mem[wr_idx] <= wr_count;
			flag_mem[wr_idx]  <= wr_flag;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q        <= req.command;
			owner_q      <= req.owner_id;
			sv_q         <= req.slot_value;
			free_idx_q   <= free_idx;
			free_found_q <= free_found;
			rd_occ_q     <= occ_q[req_idx];
		end
		if (ctl.commit)
			rsp_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.commit) begin
			if (occ_set)
				occ_q[wr_idx] <= 1'b1;
			else if (occ_clr)
				occ_q[sv_idx] <= 1'b0;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- src/refcounted_slot_allocator_core.sv -----
// Top level of the reference-counted slot allocator.
// The block keeps a table of NUM_SLOTS slots, each holding an owner id, a use
// count of COUNT_BITS bits and an assigned-by-allocator flag; slot 0 is reserved.
// A use request with slot 0 takes the lowest free slot and returns it for the
// owner's variable; a use naming a slot claims it when free or adds a use when
// the same owner holds it. An unuse request drops one use and frees the slot at
// zero, clearing the owner's variable when the allocator had chosen the slot.
// Each request is first captured, its slot entry read and the occupancy bits
// searched for the lowest free slot, then decided and written back to the
// table. A new request is taken only after the last one has been committed,
// and a result waiting on the downstream side delays the next commit. No
// clearing pass is needed after reset: per-slot occupancy bits mark the table
// free at once.
module refcounted_slot_allocator_core #(
	parameter int NUM_SLOTS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  rsa_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsa_pkg::rsp_item_t rsp
);

	rsa_pkg::rsa_ctl_t ctl;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	rsa_datapath #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
